/* src/ir_remote_dimmer_controller_defines.svh */
// Assertion macros shared by the IR remote dimmer controller RTL.
`ifndef IR_REMOTE_DIMMER_CONTROLLER_DEFINES_SVH
`define IR_REMOTE_DIMMER_CONTROLLER_DEFINES_SVH

`ifndef SYNTH

// Checks an implication in the same cycle, disabled during reset.
`define IRCD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ircd assertion failed");

// Checks an implication in the next cycle, disabled during reset.
`define IRCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ircd assertion failed");

`else

`define IRCD_ASSERT_IMP(label, ante, cons)
`define IRCD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/ircd_pkg.sv */
// Shared constants and types of the IR remote dimmer controller.
package ircd_pkg;

   localparam int LEVEL_BITS = 8;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
   // Wide enough for the level plus a step of up to 256.
   localparam int SUM_BITS = ((LEVEL_BITS > 9) ? LEVEL_BITS : 9) + 1;

   localparam logic [16:0] SINCE_MAX = 17'h1FFFF;

   // Protocol codes
   localparam logic [1:0] PROTO_RC5 = 2'd0;
   localparam logic [1:0] PROTO_NEC = 2'd1;

   // RC5 key codes
   localparam logic [15:0] RC5_KEY_POWER = 16'h000C;
   localparam logic [15:0] RC5_UP    = 16'h0010;
   localparam logic [15:0] RC5_DOWN  = 16'h0011;

   // Apple/NEC key codes
   localparam logic [15:0] NEC_POWER = 16'h005C;
   localparam logic [15:0] NEC_UP_A  = 16'h000A;
   localparam logic [15:0] NEC_UP_B  = 16'h0006;
   localparam logic [15:0] NEC_DOWN_A = 16'h000C;
   localparam logic [15:0] NEC_DOWN_B = 16'h0009;

   // Configuration register indexes
   localparam logic [1:0] CSR_REPEAT_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_SAVE_DELAY     = 2'd1;
   localparam logic [1:0] CSR_BLINK_PERIOD   = 2'd2;

   localparam logic [15:0] RESET_REPEAT_TIMEOUT = 16'd200;
   localparam logic [15:0] RESET_SAVE_DELAY     = 16'd60000;
   localparam logic [7:0]  RESET_BLINK_PERIOD   = 8'd40;

   typedef struct packed {
      logic power;
      logic up;
      logic down;
   } keys_type;

endpackage

/* src/ircd_keys.sv */
// Key decoder and power/level update for one IR frame.
module ircd_keys
   import ircd_pkg::*;
(
   input  logic                  frame,
   input  logic [1:0]            protocol,
   input  logic [15:0]           command,
   input  logic                  repeat_req,
   input  logic                  power,
   input  logic [LEVEL_BITS-1:0] level,
   input  logic [7:0]            boost,
   output logic                  power_next,
   output logic [LEVEL_BITS-1:0] level_next
);

   keys_type            keys;
   logic [SUM_BITS-1:0] step;
   logic [SUM_BITS-1:0] headroom;
   logic [SUM_BITS-1:0] level_wide;

   always_comb begin
      keys = '0;
      if (protocol == PROTO_RC5) begin
         keys.power = (command == RC5_KEY_POWER);
         keys.up    = (command == RC5_UP);
         keys.down  = (command == RC5_DOWN);
      end else if (protocol == PROTO_NEC) begin
         keys.power = (command == NEC_POWER);
         keys.up    = (command == NEC_UP_A) || (command == NEC_UP_B);
         keys.down  = (command == NEC_DOWN_A) || (command == NEC_DOWN_B);
      end
   end

   assign step       = SUM_BITS'(boost) + SUM_BITS'(1);
   assign level_wide = SUM_BITS'(level);
   assign headroom   = SUM_BITS'(LEVEL_MAX - level);

   always_comb begin
      power_next = power;
      level_next = level;
      if (frame) begin
         if (keys.power) begin
            if (!repeat_req) begin
               power_next = ~power;
               // Coming on at zero would look like still off.
               if (!power && (level == '0)) begin
                  level_next = LEVEL_BITS'(1);
               end
            end
         end else if (keys.up) begin
            if (power && (level < LEVEL_MAX)) begin
               if (headroom < step) begin
                  level_next = LEVEL_MAX;
               end else begin
                  level_next = LEVEL_BITS'(level_wide + step);
               end
            end
         end else if (keys.down) begin
            if (power && (level != '0)) begin
               if (level_wide < step) begin
                  level_next = '0;
               end else begin
                  level_next = LEVEL_BITS'(level_wide - step);
               end
            end
         end
      end
   end

endmodule

/* src/ir_remote_dimmer_controller.sv */
// Top level of the IR remote dimmer controller.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | func, protocol, command, repeat_req
//   rsp     | out       | rsp_valid / rsp_ready | duty, indicator, store strobes, level, power
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_write_data
//
// Each request passes an input register and then updates the state and the result
// register, so one request is taken per cycle while the result is not stalled, and
// its result is registered as it leaves the input register. A stalled result holds
// both stages, and then the input register takes a request only while it is empty.
// Reset is synchronous and restores power on, level 1 and the default register values.
// The csr port is always ready.
`include "ir_remote_dimmer_controller_defines.svh"

module ir_remote_dimmer_controller
   import ircd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [1:0]  req_protocol,
   input  logic [15:0] req_command,
   input  logic        req_repeat_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_duty,
   output logic        rsp_indicator,
   output logic        rsp_store_level,
   output logic        rsp_store_power,
   output logic [7:0]  rsp_level_now,
   output logic        rsp_power_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   // Configuration
   logic [15:0] repeat_timeout_ff;
   logic [15:0] save_delay_ff;
   logic [7:0]  blink_period_ff;

   // Input stage
   logic        in_valid_ff, in_valid_in;
   logic        in_func_ff;
   logic [1:0]  in_protocol_ff;
   logic [15:0] in_command_ff;
   logic        in_repeat_ff;

   // State
   logic                  power_ff, power_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [7:0]            boost_ff, boost_in;
   logic                  burst_ff, burst_in;
   logic [15:0]           idle_ff, idle_in;
   logic [16:0]           since_ff, since_in;
   logic [LEVEL_BITS-1:0] stored_level_ff, stored_level_in;
   logic                  stored_power_ff, stored_power_in;
   logic [3:0]            blink_count_ff, blink_count_in;
   logic [7:0]            blink_elapsed_ff, blink_elapsed_in;
   logic                  blink_running_ff, blink_running_in;
   logic                  led_ff, led_in;

   // Result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_duty_ff;
   logic        rsp_indicator_ff;
   logic        rsp_store_level_ff, rsp_store_power_ff;
   logic [7:0]  rsp_level_ff;
   logic        rsp_power_ff;
   logic        store_level_in, store_power_in;

   logic                  advance;
   logic                  load_in;
   logic                  do_step;
   logic                  key_power;
   logic [LEVEL_BITS-1:0] key_level;
   logic [16:0]           idle_inc;
   logic [8:0]            elapsed;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign load_in   = req_valid && req_ready;
   assign do_step   = in_valid_ff && advance;
   assign csr_ready = 1'b1;

   assign in_valid_in  = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = do_step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   ircd_keys u_keys (
      .frame      (in_func_ff),
      .protocol   (in_protocol_ff),
      .command    (in_command_ff),
      .repeat_req (in_repeat_ff),
      .power      (power_ff),
      .level      (level_ff),
      .boost      (boost_ff),
      .power_next (key_power),
      .level_next (key_level)
   );

   assign idle_inc = {1'b0, idle_ff} + 17'd1;

   always_comb begin
      power_in         = key_power;
      level_in         = key_level;
      boost_in         = boost_ff;
      burst_in         = burst_ff;
      idle_in          = idle_ff;
      since_in         = since_ff;
      led_in           = led_ff;
      elapsed          = {1'b0, blink_elapsed_ff};
      stored_level_in  = stored_level_ff;
      stored_power_in  = stored_power_ff;
      blink_count_in   = blink_count_ff;
      blink_running_in = blink_running_ff;
      store_level_in   = 1'b0;
      store_power_in   = 1'b0;

      if (in_func_ff) begin
         led_in = 1'b1;
         // Boost grows only on a repeat within a running burst.
         if (burst_ff && in_repeat_ff) begin
            boost_in = boost_ff + 8'd1;
         end
         burst_in = 1'b1;
         idle_in  = '0;
         since_in = '0;
      end else begin
         if (since_ff != SINCE_MAX) begin
            since_in = since_ff + 17'd1;
         end
         elapsed = {1'b0, blink_elapsed_ff} + 9'd1;
         if (burst_ff) begin
            if (idle_inc > {1'b0, repeat_timeout_ff}) begin
               led_in   = 1'b0;
               burst_in = 1'b0;
               idle_in  = '0;
               boost_in = '0;
            end else begin
               idle_in = idle_inc[15:0];
            end
         end
      end

      if (since_in > {1'b0, save_delay_ff}) begin
         if (stored_level_ff != level_in) begin
            stored_level_in = level_in;
            store_level_in  = 1'b1;
            blink_count_in  = 4'd1;
         end
         if (stored_power_ff != power_in) begin
            stored_power_in = power_in;
            store_power_in  = 1'b1;
            blink_count_in  = 4'd1;
         end
      end

      // The first toggle of a blink is immediate; later ones wait for the period.
      if ((blink_count_in != '0) &&
          (!blink_running_ff || (elapsed > {1'b0, blink_period_ff}))) begin
         led_in           = ~led_in;
         blink_count_in   = blink_count_in + 4'd1;
         blink_running_in = 1'b1;
         elapsed          = '0;
      end
      blink_elapsed_in = elapsed[8] ? 8'hFF : elapsed[7:0];
      if ((blink_count_in == '0) && blink_running_in) begin
         led_in           = 1'b0;
         blink_running_in = 1'b0;
         blink_elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_timeout_ff <= RESET_REPEAT_TIMEOUT;
         save_delay_ff     <= RESET_SAVE_DELAY;
         blink_period_ff   <= RESET_BLINK_PERIOD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REPEAT_TIMEOUT: repeat_timeout_ff <= csr_write_data;
            CSR_SAVE_DELAY:     save_delay_ff     <= csr_write_data;
            CSR_BLINK_PERIOD:   blink_period_ff   <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_func_ff     <= req_func;
         in_protocol_ff <= req_protocol;
         in_command_ff  <= req_command;
         in_repeat_ff   <= req_repeat_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff         <= 1'b1;
         level_ff         <= LEVEL_BITS'(1);
         boost_ff         <= '0;
         burst_ff         <= 1'b0;
         idle_ff          <= '0;
         since_ff         <= '0;
         stored_level_ff  <= LEVEL_BITS'(1);
         stored_power_ff  <= 1'b1;
         blink_count_ff   <= '0;
         blink_elapsed_ff <= '0;
         blink_running_ff <= 1'b0;
         led_ff           <= 1'b0;
      end else if (do_step) begin
         power_ff         <= power_in;
         level_ff         <= level_in;
         boost_ff         <= boost_in;
         burst_ff         <= burst_in;
         idle_ff          <= idle_in;
         since_ff         <= since_in;
         stored_level_ff  <= stored_level_in;
         stored_power_ff  <= stored_power_in;
         blink_count_ff   <= blink_count_in;
         blink_elapsed_ff <= blink_elapsed_in;
         blink_running_ff <= blink_running_in;
         led_ff           <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_step) begin
         rsp_duty_ff        <= power_in ? 8'(level_in) : 8'd0;
         rsp_indicator_ff   <= led_in;
         rsp_store_level_ff <= store_level_in;
         rsp_store_power_ff <= store_power_in;
         rsp_level_ff       <= 8'(level_in);
         rsp_power_ff       <= power_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty        = rsp_duty_ff;
   assign rsp_indicator   = rsp_indicator_ff;
   assign rsp_store_level = rsp_store_level_ff;
   assign rsp_store_power = rsp_store_power_ff;
   assign rsp_level_now   = rsp_level_ff;
   assign rsp_power_now   = rsp_power_ff;

   `IRCD_ASSERT_IMP(a_boost_only_in_burst, !burst_ff, boost_ff == 8'd0)
   `IRCD_ASSERT_IMP(a_blink_idle_when_done, blink_count_ff == 4'd0, !blink_running_ff)
   `IRCD_ASSERT_IMP(a_duty_needs_power, rsp_valid_ff && (rsp_duty_ff != 8'd0), rsp_power_ff)
   `IRCD_ASSERT_IMP(a_store_matches_level, rsp_valid_ff && rsp_store_level_ff, 8'(stored_level_ff) == rsp_level_ff)
   `IRCD_ASSERT_NEXT(a_result_after_step, do_step, rsp_valid_ff)

endmodule
